### rtl/gsa_pkg.sv
package gsa_pkg;

    typedef enum logic [1:0] {
        REQ_ALLOC     = 2'd0,
        REQ_FREE      = 2'd1,
        REQ_MAKE_REF  = 2'd2,
        REQ_CHECK_REF = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    localparam int CFG_POOLS_IN_USE = 0;
    localparam int CFG_CAP_ONE      = 1;
    localparam int CFG_CAP_TWO      = 2;
    localparam int CFG_CAP_THREE    = 3;
    localparam int CFG_CAP_FOUR     = 4;

    localparam int CAP_REGS   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int POOL_ID_W  = 3;
    localparam int SLOT_W     = 16;
    localparam int GEN_W      = 16;
    localparam int REF_W      = 32;
    localparam int GRANT_W    = 8;
    localparam int CAP_W      = 16;

    localparam logic [GEN_W-1:0] GEN_MAX   = 16'hFFFF;
    localparam logic [GEN_W-1:0] GEN_FIRST = 16'h0001;

    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

endpackage

### rtl/generational_slot_allocator.sv
// free, make ref and check ref read the memories on accept and register the result
// from the execute state; alloc scans bitmap words of 32 slots (8 if a pool has under 32),
// at least one, at most ceil(capacity/word size); a stalled result holds the item longer
// one item in flight; next item accepted the cycle after the result is registered
// the bitmap and generation memories give one word each per cycle, setting the scan rate
// unless a stalled result holds it; reset: synchronous active low, then a clearing pass
// sets every generation to one and every bitmap bit to free, with s_tready low meanwhile
module generational_slot_allocator #(
    parameter int NUM_POOLS      = 4,
    parameter int SLOTS_PER_POOL = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // req_type
    input  logic [gsa_pkg::S_TUSER_W-1:0]       s_tuser,
    // pool_id [2:0], slot_index [18:3], packed_ref [50:19], zero fill
    input  logic [gsa_pkg::S_TDATA_W-1:0]       s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [0], granted_slot [8:1], made_ref [40:9], ref_is_current [41], zero fill
    output logic [gsa_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int TOTAL     = NUM_POOLS * SLOTS_PER_POOL;
    localparam int WORD_BITS = (SLOTS_PER_POOL >= 32) ? 32 : 8;
    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int WPP       = (SLOTS_PER_POOL + WORD_BITS - 1) / WORD_BITS;
    localparam int BM_DEPTH  = NUM_POOLS * WPP;
    localparam int GA        = $clog2(TOTAL);
    localparam int BA        = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
    localparam int PW        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int BASE_W    = gsa_pkg::CAP_W + 1;

    // configuration
    logic [gsa_pkg::POOL_ID_W-1:0]  pools_reg;
    logic [gsa_pkg::CFG_DATA_W-1:0] cap_reg [gsa_pkg::CAP_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pools_reg <= '0;
            for (int i = 0; i < gsa_pkg::CAP_REGS; i++) begin
                cap_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (int'(cfg_index))
                gsa_pkg::CFG_POOLS_IN_USE: pools_reg  <= cfg_wdata[gsa_pkg::POOL_ID_W-1:0];
                gsa_pkg::CFG_CAP_ONE:      cap_reg[0] <= cfg_wdata;
                gsa_pkg::CFG_CAP_TWO:      cap_reg[1] <= cfg_wdata;
                gsa_pkg::CFG_CAP_THREE:    cap_reg[2] <= cfg_wdata;
                gsa_pkg::CFG_CAP_FOUR:     cap_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    gsa_pkg::req_type_t              in_req;
    logic [gsa_pkg::POOL_ID_W-1:0]   in_pid;
    logic [gsa_pkg::SLOT_W-1:0]      in_slot;
    logic [gsa_pkg::REF_W-1:0]       in_ref;
    logic [gsa_pkg::SLOT_W-1:0]      in_eff_slot;
    logic                            in_pool_ok;
    logic [PW-1:0]                   in_pool0;
    logic [gsa_pkg::CAP_W-1:0]       in_cap_raw;
    logic [gsa_pkg::CAP_W-1:0]       in_cap;

    assign in_req      = gsa_pkg::req_type_t'(s_tuser);
    assign in_pid      = s_tdata[2:0];
    assign in_slot     = s_tdata[18:3];
    assign in_ref      = s_tdata[50:19];
    assign in_eff_slot = (in_req == gsa_pkg::REQ_CHECK_REF) ? in_ref[15:0] : in_slot;
    assign in_pool_ok  = (in_pid != '0) && (in_pid <= pools_reg) && (int'(in_pid) <= NUM_POOLS);
    assign in_pool0    = PW'(in_pid) - PW'(1);

    always_comb begin
        case (int'(in_pool0))
            0:       in_cap_raw = gsa_pkg::CAP_W'(cap_reg[0]);
            1:       in_cap_raw = gsa_pkg::CAP_W'(cap_reg[1]);
            2:       in_cap_raw = gsa_pkg::CAP_W'(cap_reg[2]);
            3:       in_cap_raw = gsa_pkg::CAP_W'(cap_reg[3]);
            default: in_cap_raw = '0;
        endcase
        in_cap = (in_cap_raw > gsa_pkg::CAP_W'(SLOTS_PER_POOL))
               ? gsa_pkg::CAP_W'(SLOTS_PER_POOL) : in_cap_raw;
    end

    // control
    gsa_pkg::state_t state_reg, state_next;
    logic [GA-1:0]   clr_cnt_reg;
    logic            accept;
    logic            out_free;
    logic            done;
    logic            scan_adv;

    assign s_tready = (state_reg == gsa_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    // request held while it executes
    gsa_pkg::req_type_t            req_reg;
    logic                          pool_ok_reg;
    logic [gsa_pkg::SLOT_W-1:0]    slot_reg;
    logic [gsa_pkg::REF_W-1:0]     ref_reg;
    logic [gsa_pkg::CAP_W-1:0]     cap_eff_reg;
    logic [BASE_W-1:0]             scan_base_reg;
    logic [BA-1:0]                 bm_addr_reg;
    logic [GA-1:0]                 gen_addr_reg;

    // memories
    logic [WORD_BITS-1:0]          bm_mem [BM_DEPTH];
    logic [gsa_pkg::GEN_W-1:0]     gen_mem [TOTAL];
    logic [WORD_BITS-1:0]          bm_rdata_reg;
    logic [gsa_pkg::GEN_W-1:0]     gen_rdata_reg;

    logic                          bm_rd_en;
    logic [BA-1:0]                 bm_rd_addr;
    logic [GA-1:0]                 gen_rd_addr;
    logic                          bm_we, gen_we;
    logic [BA-1:0]                 bm_wa;
    logic [GA-1:0]                 gen_wa;
    logic [WORD_BITS-1:0]          bm_wd;
    logic [gsa_pkg::GEN_W-1:0]     gen_wd;

    // execution
    logic [WORD_BITS-1:0]          cand;
    logic                          found;
    logic [WB_LOG-1:0]             fidx;
    logic [BASE_W-1:0]             next_base;
    logic [WB_LOG-1:0]             bit_sel;
    logic                          live;
    logic                          ex_we_bm, ex_we_gen;
    logic [WORD_BITS-1:0]          ex_bm_wd;
    logic [gsa_pkg::GEN_W-1:0]     ex_gen_wd;
    logic                          res_status;
    logic [gsa_pkg::GRANT_W-1:0]   res_grant;
    logic [gsa_pkg::REF_W-1:0]     res_made;
    logic                          res_cur;

    assign bit_sel   = slot_reg[WB_LOG-1:0];
    assign next_base = scan_base_reg + BASE_W'(WORD_BITS);
    assign live      = pool_ok_reg && (slot_reg < cap_eff_reg) && bm_rdata_reg[bit_sel];

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            cand[b] = !bm_rdata_reg[b]
                   && ((scan_base_reg + BASE_W'(b)) < BASE_W'(cap_eff_reg));
        end
        found = 1'b0;
        fidx  = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                found = 1'b1;
                fidx  = WB_LOG'(b);
            end
        end
    end

    always_comb begin
        done       = 1'b0;
        scan_adv   = 1'b0;
        ex_we_bm   = 1'b0;
        ex_we_gen  = 1'b0;
        ex_bm_wd   = bm_rdata_reg;
        ex_gen_wd  = (gen_rdata_reg >= gsa_pkg::GEN_MAX)
                   ? gsa_pkg::GEN_FIRST : gen_rdata_reg + gsa_pkg::GEN_FIRST;
        res_status = 1'b0;
        res_grant  = '0;
        res_made   = '0;
        res_cur    = 1'b0;
        if (state_reg == gsa_pkg::ST_EXEC && out_free) begin
            case (req_reg)
                gsa_pkg::REQ_ALLOC: begin
                    if (pool_ok_reg && found) begin
                        done          = 1'b1;
                        ex_we_bm      = 1'b1;
                        ex_bm_wd[fidx] = 1'b1;
                        res_grant     = gsa_pkg::GRANT_W'(scan_base_reg + BASE_W'(fidx));
                    end else if (!pool_ok_reg || next_base >= BASE_W'(cap_eff_reg)) begin
                        done       = 1'b1;
                        res_status = 1'b1;
                    end else begin
                        scan_adv = 1'b1;
                    end
                end
                gsa_pkg::REQ_FREE: begin
                    done = 1'b1;
                    if (live) begin
                        ex_we_bm          = 1'b1;
                        ex_we_gen         = 1'b1;
                        ex_bm_wd[bit_sel] = 1'b0;
                    end else begin
                        res_status = 1'b1;
                    end
                end
                gsa_pkg::REQ_MAKE_REF: begin
                    done = 1'b1;
                    if (live) begin
                        res_made = {gen_rdata_reg, slot_reg};
                    end else begin
                        res_status = 1'b1;
                    end
                end
                default: begin
                    done    = 1'b1;
                    res_cur = live && (ref_reg != '0)
                           && (gen_rdata_reg == ref_reg[31:16]);
                end
            endcase
        end
    end

    // memory addressing
    always_comb begin
        if (scan_adv) begin
            bm_rd_addr = bm_addr_reg + BA'(1);
        end else if (in_req == gsa_pkg::REQ_ALLOC) begin
            bm_rd_addr = BA'(in_pool0) * BA'(WPP);
        end else begin
            bm_rd_addr = BA'(in_pool0) * BA'(WPP) + BA'(in_eff_slot >> WB_LOG);
        end
        gen_rd_addr = GA'(in_pool0) * GA'(SLOTS_PER_POOL) + GA'(in_eff_slot);
        bm_rd_en    = accept || scan_adv;

        if (state_reg == gsa_pkg::ST_CLEAR) begin
            bm_we  = (int'(clr_cnt_reg) < BM_DEPTH);
            bm_wa  = BA'(clr_cnt_reg);
            bm_wd  = '0;
            gen_we = 1'b1;
            gen_wa = clr_cnt_reg;
            gen_wd = gsa_pkg::GEN_FIRST;
        end else begin
            bm_we  = ex_we_bm;
            bm_wa  = bm_addr_reg;
            bm_wd  = ex_bm_wd;
            gen_we = ex_we_gen;
            gen_wa = gen_addr_reg;
            gen_wd = ex_gen_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_wa] <= bm_wd;
        end
        if (bm_rd_en) begin
            bm_rdata_reg <= bm_mem[bm_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (gen_we) begin
            gen_mem[gen_wa] <= gen_wd;
        end
        if (accept) begin
            gen_rdata_reg <= gen_mem[gen_rd_addr];
        end
    end

    // state machine
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gsa_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == GA'(TOTAL - 1)) state_next = gsa_pkg::ST_IDLE;
            end
            gsa_pkg::ST_IDLE: begin
                if (accept) state_next = gsa_pkg::ST_EXEC;
            end
            gsa_pkg::ST_EXEC: begin
                if (done) state_next = gsa_pkg::ST_IDLE;
            end
            default: state_next = gsa_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gsa_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == gsa_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + GA'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg       <= in_req;
            pool_ok_reg   <= in_pool_ok;
            slot_reg      <= in_eff_slot;
            ref_reg       <= in_ref;
            cap_eff_reg   <= in_cap;
            scan_base_reg <= '0;
            gen_addr_reg  <= gen_rd_addr;
        end else if (scan_adv) begin
            scan_base_reg <= next_base;
        end
        if (bm_rd_en) begin
            bm_addr_reg <= bm_rd_addr;
        end
    end

    // output register
    logic                          m_valid_reg;
    logic [gsa_pkg::M_TDATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= {6'b0, res_cur, res_made, res_grant, res_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### rtl/gsa_checker.sv
module gsa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gsa_pkg::M_TDATA_W-1:0] m_tdata
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // a failure carries no slot and no ref
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[8:1] == '0 && m_tdata[40:9] == '0
                                   && !m_tdata[41])
        else $error("failed item carries payload");

    // generations never reach zero
    a_ref_gen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40:9] != '0 |-> m_tdata[40:25] != '0)
        else $error("made ref with zero generation");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/generational_slot_allocator_test.sv
`timescale 1ns / 100ps

module generational_slot_allocator_test;

    localparam int NUM_POOLS      = 4;
    localparam int SLOTS_PER_POOL = 256;
    localparam int TOTAL_SLOTS    = NUM_POOLS * SLOTS_PER_POOL;
    localparam int RANDOM_ITEMS   = 1152;
    localparam int RANDOM_PHASES  = 6;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int HANDLE_HISTORY = 64;
    localparam int GEN_CYCLES     = 30;

    typedef struct packed {
        logic        status;
        logic [7:0]  granted_slot;
        logic [31:0] made_ref;
        logic        ref_is_current;
    } slot_reply_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [gsa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gsa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    // req_type
    logic [gsa_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    // pool_id, slot_index, packed_ref, zero fill
    logic [gsa_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // status, granted_slot, made_ref, ref_is_current, zero fill
    logic [gsa_pkg::M_TDATA_W-1:0]  m_tdata;

    // mirror of the allocator state
    bit          live_map [TOTAL_SLOTS];
    logic [15:0] gen_mem  [TOTAL_SLOTS];
    logic [2:0]  pools_cfg;
    logic [8:0]  cap_cfg  [gsa_pkg::CAP_REGS];

    slot_reply_t pending_replies [$];
    logic [34:0] issued_handles  [$];
    slot_reply_t oldest_reply;

    int  items_sent      = 0;
    int  replies_checked = 0;
    int  mismatch_count  = 0;
    int  settings_tried  = 0;
    int  burst_left      = 0;
    int  sender_gap_max  = 4;
    bit  steady_ready    = 1'b0;
    int  pattern_cycle   = 0;
    int  stall_pct       = 0;
    int  stall_run       = 0;
    int  quiet_cycles    = 0;

    generational_slot_allocator #(
        .NUM_POOLS      (NUM_POOLS),
        .SLOTS_PER_POOL (SLOTS_PER_POOL)
    ) DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int usable_slots(logic [2:0] pool);
        int cap;
        if (pool == 0 || pool > pools_cfg || pool > NUM_POOLS || pool > gsa_pkg::CAP_REGS)
            return 0;
        cap = cap_cfg[pool - 1];
        return (cap > SLOTS_PER_POOL) ? SLOTS_PER_POOL : cap;
    endfunction

    function automatic int slot_addr(logic [2:0] pool, int slot);
        return (int'(pool) - 1) * SLOTS_PER_POOL + slot;
    endfunction

    // slots beyond the capacity in force count as free
    function automatic bit slot_live(logic [2:0] pool, logic [15:0] slot);
        return (slot < usable_slots(pool)) && live_map[slot_addr(pool, slot)];
    endfunction

    function automatic slot_reply_t serve_request(gsa_pkg::req_type_t req, logic [2:0] pool,
                                                  logic [15:0] slot, logic [31:0] handle);
        slot_reply_t reply;
        int          cap;
        int          addr;
        reply = '0;
        cap   = usable_slots(pool);
        case (req)
            gsa_pkg::REQ_ALLOC: begin
                reply.status = 1'b1;
                for (int s = 0; s < cap; s++) begin
                    if (!live_map[slot_addr(pool, s)]) begin
                        live_map[slot_addr(pool, s)] = 1'b1;
                        reply.granted_slot = s[7:0];
                        reply.status = 1'b0;
                        break;
                    end
                end
            end
            gsa_pkg::REQ_FREE: begin
                reply.status = 1'b1;
                if (slot_live(pool, slot)) begin
                    addr = slot_addr(pool, slot);
                    live_map[addr] = 1'b0;
                    gen_mem[addr] = (gen_mem[addr] == gsa_pkg::GEN_MAX) ? gsa_pkg::GEN_FIRST
                                                                        : gen_mem[addr] + 16'd1;
                    reply.status = 1'b0;
                end
            end
            gsa_pkg::REQ_MAKE_REF: begin
                reply.status = 1'b1;
                if (slot_live(pool, slot)) begin
                    reply.made_ref = {gen_mem[slot_addr(pool, slot)], slot};
                    reply.status = 1'b0;
                end
            end
            default: begin
                if (handle != 0 && slot_live(pool, handle[15:0]))
                    reply.ref_is_current =
                        (gen_mem[slot_addr(pool, handle[15:0])] == handle[31:16]);
            end
        endcase
        return reply;
    endfunction

    task automatic send_request(gsa_pkg::req_type_t req, logic [2:0] pool, logic [15:0] slot,
                                logic [31:0] handle);
        slot_reply_t reply;
        int          gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, sender_gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= gsa_pkg::S_TDATA_W'({handle, slot, pool});
        do @(posedge aclk); while (s_tready !== 1'b1);
        reply = serve_request(req, pool, slot, handle);
        pending_replies.push_back(reply);
        if (req == gsa_pkg::REQ_MAKE_REF && !reply.status) begin
            issued_handles.push_back({pool, reply.made_ref});
            if (issued_handles.size() > HANDLE_HISTORY)
                void'(issued_handles.pop_front());
        end
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        // let the bench sit idle before the next step
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_register(int index, logic [8:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= gsa_pkg::CFG_IDX_W'(index);
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (index == gsa_pkg::CFG_POOLS_IN_USE)
            pools_cfg = value[2:0];
        else
            cap_cfg[index - 1] = value;
    endtask

    task automatic set_pool_config(logic [2:0] pools, logic [8:0] cap_one, logic [8:0] cap_two,
                                   logic [8:0] cap_three, logic [8:0] cap_four);
        wait_until_drained();
        write_register(gsa_pkg::CFG_POOLS_IN_USE, 9'(pools));
        write_register(gsa_pkg::CFG_CAP_ONE, cap_one);
        write_register(gsa_pkg::CFG_CAP_TWO, cap_two);
        write_register(gsa_pkg::CFG_CAP_THREE, cap_three);
        write_register(gsa_pkg::CFG_CAP_FOUR, cap_four);
        settings_tried++;
    endtask

    function automatic logic [8:0] random_capacity();
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'($urandom_range(2, 40));
            3: return 9'd256;
            4: return 9'd511;
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    // with no pools declared every request must be refused
    task automatic test_reset_defaults();
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0, 32'h0001_0000);
        send_request(gsa_pkg::REQ_ALLOC, 3'd0, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd4, 16'd0, 32'd0);
    endtask

    task automatic test_directed_cases();
        set_pool_config(3'd2, 9'd3, 9'd0, 9'd256, 9'd511);
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        // pool full, zero capacity, then pool ids out of range
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd2, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd0, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd3, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'd1, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0, 32'h0001_0001);
        send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd1, 32'd0);
        // stale handle, then double free
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0, 32'h0001_0001);
        send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd1, 32'd0);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'd3, 32'd0);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'hFFFF, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'd1, 32'd0);
        send_request(gsa_pkg::REQ_FREE, 3'd3, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd0, 16'd0, 32'h0002_0001);
    endtask

    // slots left live above a lowered capacity must stay hidden until it rises again
    task automatic test_capacity_shrink();
        set_pool_config(3'd2, 9'd1, 9'd0, 9'd256, 9'd511);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'd2, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0, 32'h0001_0002);
        send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd2, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        set_pool_config(3'd2, 9'd3, 9'd0, 9'd256, 9'd511);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'd2, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0, 32'h0001_0002);
        for (int s = 0; s < 3; s++)
            send_request(gsa_pkg::REQ_FREE, 3'd1, 16'(s), 32'd0);
    endtask

    // cycle one slot back to back and check that handles follow its generation
    task automatic test_generation_advance();
        set_pool_config(3'd1, 9'd1, 9'd0, 9'd0, 9'd0);
        sender_gap_max = 0;
        steady_ready   = 1'b1;
        if (live_map[slot_addr(3'd1, 0)])
            send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd0, 32'd0);
        repeat (GEN_CYCLES) begin
            send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
            send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd0, 32'd0);
        end
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_MAKE_REF, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0,
                     {gen_mem[slot_addr(3'd1, 0)], 16'd0});
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0,
                     {gen_mem[slot_addr(3'd1, 0)] - 16'd1, 16'd0});
        send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_ALLOC, 3'd1, 16'd0, 32'd0);
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0,
                     {gen_mem[slot_addr(3'd1, 0)] - 16'd1, 16'd0});
        send_request(gsa_pkg::REQ_CHECK_REF, 3'd1, 16'd0, 32'h0001_0000);
        send_request(gsa_pkg::REQ_FREE, 3'd1, 16'd0, 32'd0);
        wait_until_drained();
        steady_ready = 1'b0;
    endtask

    task automatic random_request();
        gsa_pkg::req_type_t req;
        logic [2:0]  pool;
        logic [15:0] slot;
        logic [31:0] handle;
        logic [34:0] issued;
        int          roll;
        int          cap;
        int          top_pool;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            req = gsa_pkg::REQ_ALLOC;
        else if (roll < 60)
            req = gsa_pkg::REQ_FREE;
        else if (roll < 80)
            req = gsa_pkg::REQ_MAKE_REF;
        else
            req = gsa_pkg::REQ_CHECK_REF;
        top_pool = (pools_cfg > NUM_POOLS) ? NUM_POOLS : pools_cfg;
        if (top_pool != 0 && $urandom_range(0, 9) != 0)
            pool = 3'($urandom_range(1, top_pool));
        else
            pool = 3'($urandom_range(0, 7));
        cap = usable_slots(pool);
        if (cap != 0 && $urandom_range(0, 9) != 0)
            slot = 16'($urandom_range(0, cap - 1));
        else
            slot = 16'($urandom_range(0, 16'hFFFF));
        handle = $urandom;
        if (req == gsa_pkg::REQ_CHECK_REF) begin
            roll = $urandom_range(0, 99);
            if (roll < 45 && issued_handles.size() != 0) begin
                issued = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
                pool   = issued[34:32];
                handle = issued[31:0];
            end else if (roll < 80 && slot < cap) begin
                handle = {gen_mem[slot_addr(pool, slot)], slot};
            end else if (roll < 90) begin
                handle = 32'd0;
            end
            // now and then a handle with one bit flipped
            if ($urandom_range(0, 19) == 0)
                handle ^= 32'h1 << $urandom_range(0, 31);
        end
        send_request(req, pool, slot, handle);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_pool_config(3'd4, 9'd256, 9'd256, 9'd256, 9'd256);
                1: set_pool_config(3'd7, 9'd511, 9'd300, 9'd1, 9'd0);
                2: set_pool_config(3'd3, 9'd8, 9'd33, 9'd5, 9'd256);
                default: set_pool_config(3'($urandom_range(0, 7)), random_capacity(),
                                         random_capacity(), random_capacity(),
                                         random_capacity());
            endcase
            sender_gap_max = (phase == 2) ? 0 : $urandom_range(2, 10);
            repeat (RANDOM_ITEMS / RANDOM_PHASES) begin
                random_request();
                if ($urandom_range(0, 149) == 0)
                    wait_until_drained();
            end
        end
    endtask

    // receiver: stall density is redrawn each time pattern_cycle wraps
    always @(posedge aclk) begin
        if (pattern_cycle == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
        end
        pattern_cycle = (pattern_cycle + 1) % 256;
        if (steady_ready) begin
            m_tready <= 1'b1;
        end else if (stall_run != 0) begin
            m_tready <= 1'b0;
            stall_run--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_tready <= 1'b0;
            stall_run = $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: reply with none expected, expected nothing, got %0h",
                         $time, m_tdata);
            end else begin
                oldest_reply = pending_replies.pop_front();
                compare_field("status", oldest_reply.status, m_tdata[0]);
                compare_field("granted_slot", oldest_reply.granted_slot, m_tdata[8:1]);
                compare_field("made_ref", oldest_reply.made_ref, m_tdata[40:9]);
                compare_field("ref_is_current", oldest_reply.ref_is_current, m_tdata[41]);
                replies_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            live_map[i] = 1'b0;
            gen_mem[i]  = gsa_pkg::GEN_FIRST;
        end
        pools_cfg = '0;
        for (int i = 0; i < gsa_pkg::CAP_REGS; i++)
            cap_cfg[i] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing pass holds s_tready low
        do @(posedge aclk); while (s_tready !== 1'b1);

        test_reset_defaults();
        test_directed_cases();
        test_capacity_shrink();
        test_generation_advance();
        test_random_traffic();
        wait_until_drained();

        $display("%0d requests sent, %0d replies compared, %0d pool settings applied",
                 items_sent, replies_checked, settings_tried);
        $display("covered bad pool ids, full and empty pools, stale handles, shrink and reuse");
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
